[sv/sosgu_pkg.sv]
`default_nettype none

package sosgu_pkg;

    // Ring and height geometry
    localparam int SITES      = 256;
    localparam int SITE_W     = $clog2(SITES);
    localparam int MAX_HEIGHT = 20;
    localparam int MID_HEIGHT = MAX_HEIGHT / 2;
    localparam int H_W        = $clog2(MAX_HEIGHT + 1);
    localparam int ORD_W      = 12;

    // Threshold registers, Q1.32: one integer bit so that 1.0 fits
    localparam int NUM_THR   = 6;
    localparam int THR_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam logic [THR_W-1:0] THR_ONE = {1'b1, {(THR_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] THR_DOWN_AWAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] THR_FLAT_AWAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] THR_UP_AWAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] THR_DOWN_TOWARD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] THR_FLAT_TOWARD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] THR_UP_TOWARD   = 3'd5;

    typedef struct packed {
        logic [7:0]  site_index;
        logic        step_up;
        logic [31:0] rand_value;
    } t_req;

    typedef struct packed {
        logic             accepted;
        logic [4:0]       site_height;
        logic [ORD_W-1:0] order_sum;
    } t_res;

    typedef enum logic [1:0] {
        SEL_SITE,
        SEL_LEFT,
        SEL_RIGHT
    } t_rd_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_h;
        logic    cap_l;
        logic    cap_r;
        logic    eval;
    } t_dp_cmd;

endpackage

`default_nettype wire

[sv/sosgu_ram.sv]
`default_nettype none

module sosgu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/sosgu_ctrl.sv]
`default_nettype none

module sosgu_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    output sosgu_pkg::t_dp_cmd     o_cmd
);

    import sosgu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_SITE,
        S_RD_LEFT,
        S_RD_RIGHT,
        S_CAP,
        S_EVAL
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    t_dp_cmd r_cmd;
    t_dp_cmd n_cmd;
    logic    w_load;

    assign w_load = i_start && !r_busy;

    always_comb begin
        n_state        = r_state;
        n_cmd          = '0;
        n_cmd.rd_sel   = SEL_SITE;
        case (r_state)
            S_IDLE: begin
                if (w_load) begin
                    n_state      = S_RD_SITE;
                    n_cmd.rd_en  = 1'b1;
                    n_cmd.rd_sel = SEL_SITE;
                end
            end
            S_RD_SITE: begin
                n_state      = S_RD_LEFT;
                n_cmd.rd_en  = 1'b1;
                n_cmd.rd_sel = SEL_LEFT;
                n_cmd.cap_h  = 1'b1;
            end
            S_RD_LEFT: begin
                n_state      = S_RD_RIGHT;
                n_cmd.rd_en  = 1'b1;
                n_cmd.rd_sel = SEL_RIGHT;
                n_cmd.cap_l  = 1'b1;
            end
            S_RD_RIGHT: begin
                n_state     = S_CAP;
                n_cmd.cap_r = 1'b1;
            end
            S_CAP: begin
                n_state    = S_EVAL;
                n_cmd.eval = 1'b1;
            end
            S_EVAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_cmd   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_cmd   <= n_cmd;
        end
    end

    // load acts on the accepting edge itself, the rest follows the state
    always_comb begin
        o_cmd      = r_cmd;
        o_cmd.load = w_load;
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

[sv/sosgu_dp.sv]
`default_nettype none

module sosgu_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sosgu_pkg::t_dp_cmd                  i_cmd,
    input  wire sosgu_pkg::t_req                     i_req,
    input  wire logic                                i_cfg_we,
    input  wire logic [sosgu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sosgu_pkg::THR_W-1:0]         i_cfg_data,
    output logic                                     o_strobe,
    output sosgu_pkg::t_res                          o_res
);

    import sosgu_pkg::*;

    localparam logic [H_W-1:0]    MID_H    = H_W'(MID_HEIGHT);
    localparam logic [H_W-1:0]    MAX_H    = H_W'(MAX_HEIGHT);
    localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(SITES - 1);

    logic [THR_W-1:0]  r_thr [NUM_THR];
    logic [SITES-1:0]  r_valid;
    logic [ORD_W-1:0]  r_order;

    logic [SITE_W-1:0] r_site;
    logic              r_up;
    logic [31:0]       r_rand;
    logic [H_W-1:0]    r_h;
    logic [H_W-1:0]    r_hl;
    logic [H_W-1:0]    r_hr;
    logic              r_rd_valid;

    logic              r_strobe;
    t_res              r_res;

    logic [SITE_W-1:0]    w_left;
    logic [SITE_W-1:0]    w_right;
    logic [SITE_W-1:0]    w_raddr;
    logic [H_W-1:0]       w_rdata;
    logic [H_W-1:0]       w_rd_h;
    logic                 w_at_edge;
    logic [H_W-1:0]       w_hn;
    logic                 w_l_dn;
    logic                 w_r_dn;
    logic [1:0]           w_bond_off;
    logic                 w_away;
    logic [CFG_IDX_W-1:0] w_sel;
    logic [THR_W-1:0]     w_thr;
    logic                 w_take;
    logic [ORD_W-1:0]     n_order;

    assign w_left  = (r_site == '0) ? LAST_SITE : r_site - 1'b1;
    assign w_right = (r_site == LAST_SITE) ? '0 : r_site + 1'b1;

    always_comb begin
        case (i_cmd.rd_sel)
            SEL_SITE:  w_raddr = r_site;
            SEL_LEFT:  w_raddr = w_left;
            SEL_RIGHT: w_raddr = w_right;
            default:   w_raddr = r_site;
        endcase
    end

    sosgu_ram #(
        .WIDTH (H_W),
        .DEPTH (SITES)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (i_cmd.eval && w_take),
        .i_waddr (r_site),
        .i_wdata (w_hn),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sites never written still sit at mid-height
    assign w_rd_h = r_rd_valid ? w_rdata : MID_H;

    // Move evaluation on the captured heights
    assign w_at_edge = r_up ? (r_h == MAX_H) : (r_h == '0);
    assign w_hn      = r_up ? r_h + 1'b1 : r_h - 1'b1;
    // a neighbour on the side the site moves towards shortens that bond
    assign w_l_dn    = r_up ? (r_hl > r_h) : (r_hl < r_h);
    assign w_r_dn    = r_up ? (r_hr > r_h) : (r_hr < r_h);
    assign w_bond_off = {1'b0, ~w_l_dn} + {1'b0, ~w_r_dn};
    assign w_away    = r_up ? (r_h >= MID_H) : (r_h <= MID_H);
    assign w_sel     = (w_away ? THR_DOWN_AWAY : THR_DOWN_TOWARD) + {1'b0, w_bond_off};
    assign w_thr     = r_thr[w_sel];
    assign w_take    = !w_at_edge && ({1'b0, r_rand} < w_thr);
    assign n_order   = w_take ? (w_away ? r_order + 1'b1 : r_order - 1'b1) : r_order;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_site <= SITE_W'({24'd0, i_req.site_index} % SITES);
            r_up   <= i_req.step_up;
            r_rand <= i_req.rand_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_valid <= r_valid[w_raddr];
        end
        if (i_cmd.cap_h) begin
            r_h <= w_rd_h;
        end
        if (i_cmd.cap_l) begin
            r_hl <= w_rd_h;
        end
        if (i_cmd.cap_r) begin
            r_hr <= w_rd_h;
        end
        if (i_cmd.eval) begin
            r_res.accepted    <= w_take;
            r_res.site_height <= 5'(w_take ? w_hn : r_h);
            r_res.order_sum   <= n_order;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THR; i++) begin
                r_thr[i] <= THR_ONE;
            end
            r_valid  <= '0;
            r_order  <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_THR))) begin
                r_thr[i_cfg_idx] <= i_cfg_data;
            end
            if (i_cmd.eval && w_take) begin
                r_valid[r_site] <= 1'b1;
            end
            if (i_cmd.eval) begin
                r_order <= n_order;
            end
            r_strobe <= i_cmd.eval;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

[sv/sos_interface_glauber_update_core.sv]
`default_nettype none

// Metropolis update unit for a solid-on-solid interface on a ring of heights.
// A request is taken when start is high and busy is low; its result appears
// on o_res with o_strobe high for one cycle, after the read, capture and
// evaluate states, and cannot be held off. A request completes before the
// next is taken: the height store has a single read port, so the site and its
// two ring neighbours are read one after another before the acceptance test
// and the write-back. busy is high from the edge that takes a request until
// the strobe is shown, and a new request may be given in that strobe cycle.
// The user writes thresholds through i_cfg_* while the unit is idle; the unit
// does not enforce this. Indexes above five are ignored. After reset all sites
// are at mid-height and the order sum is zero, with no clearing pass.
module sos_interface_glauber_update_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire sosgu_pkg::t_req                 i_req,
    output logic                                 o_strobe,
    output sosgu_pkg::t_res                      o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [sosgu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sosgu_pkg::THR_W-1:0]     i_cfg_data
);

    import sosgu_pkg::*;

    t_dp_cmd w_cmd;

    sosgu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    sosgu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("result did not follow request after six cycles");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request taken");

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!busy && $past(busy)))
        else $error("strobe outside the end of a request");

    a_no_reject_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.accepted) |-> (o_res.order_sum == u_dp.r_order))
        else $error("order sum moved on a rejected request");

endmodule

`default_nettype wire
